>>> rtl/rrts_pkg.sv
// shared types and constants of the round robin tick scheduler
package rrts_pkg;

   localparam int NUM_PROCS_DEFAULT  = 16;
   localparam int TICK_WIDTH_DEFAULT = 32;

   localparam int MODE_W   = 2;
   localparam int PID_W    = 4;
   localparam int STATUS_W = 2;
   localparam int TICKS_W  = 32;
   localparam int COUNT_W  = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_SLOT  = 2'd1,
      MODE_ALARM = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_UNUSED  = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_WAITING = 2'd3
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PID_W-1:0]    process_id;
      logic [STATUS_W-1:0] new_status;
      logic [TICKS_W-1:0]  sleep_ticks;
      logic [TICKS_W-1:0]  alarm_period;
   } req_payload_type;

   typedef struct packed {
      logic [PID_W-1:0]   current_pid;
      logic               switched;
      logic               alarm_fired;
      logic [COUNT_W-1:0] switch_count;
   } rsp_payload_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic tick;
      logic slot_wr;
      logic alarm_wr;
      logic tok_load;
      logic tok_shift;
   } cell_ctl_type;

endpackage

>>> rtl/rrts_stream_if.sv
// valid/ready channel carrying one payload beat
interface rrts_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/rrts_cell.sv
// one process slot: status, sleep and alarm counters, scan token
module rrts_cell #(
   parameter int TICK_WIDTH = rrts_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rrts_pkg::cell_ctl_type ctl,
   input  logic                   sel_cur,
   input  logic                   sel_slot,
   input  logic                   sel_start,
   input  logic                   sel_commit,
   input  rrts_pkg::status_type   wr_status,
   input  logic [TICK_WIDTH-1:0]  wr_sleep,
   input  logic [TICK_WIDTH-1:0]  wr_period,
   input  logic                   tok_from_prev,
   output logic                   tok,
   output logic                   hit,
   output logic                   alarm_expire
);
   import rrts_pkg::*;

   status_type            status_ff, status_in;
   logic [TICK_WIDTH-1:0] sleep_ff, sleep_in;
   logic [TICK_WIDTH-1:0] alarm_ff, alarm_in;
   logic [TICK_WIDTH-1:0] reload_ff, reload_in;
   logic                  tok_ff, tok_in;

   always_comb begin
      status_in = status_ff;
      sleep_in  = sleep_ff;
      alarm_in  = alarm_ff;
      reload_in = reload_ff;
      tok_in    = tok_ff;

      if (ctl.tick) begin
         // sleepers count down and wake at zero
         if (status_ff == ST_WAITING && sleep_ff != '0) begin
            sleep_in = sleep_ff - 1'b1;
            if (sleep_ff == TICK_WIDTH'(1)) begin
               status_in = ST_READY;
            end
         end
         if (sel_cur) begin
            if (alarm_ff == TICK_WIDTH'(1)) begin
               alarm_in = reload_ff;
            end else if (alarm_ff != '0) begin
               alarm_in = alarm_ff - 1'b1;
            end
            status_in = ST_READY;
         end
      end
      if (ctl.slot_wr && sel_slot) begin
         status_in = wr_status;
         sleep_in  = wr_sleep;
      end
      if (ctl.alarm_wr && sel_cur) begin
         reload_in = wr_period;
         alarm_in  = wr_period;
      end
      if (sel_commit) begin
         status_in = ST_RUNNING;
      end

      if (ctl.tok_load) begin
         tok_in = sel_start;
      end else if (ctl.tok_shift) begin
         tok_in = tok_from_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_UNUSED;
         sleep_ff  <= '0;
         alarm_ff  <= '0;
         reload_ff <= '0;
         tok_ff    <= 1'b0;
      end else begin
         status_ff <= status_in;
         sleep_ff  <= sleep_in;
         alarm_ff  <= alarm_in;
         reload_ff <= reload_in;
         tok_ff    <= tok_in;
      end
   end

   assign tok          = tok_ff;
   assign hit          = tok_ff && (status_ff == ST_READY);
   assign alarm_expire = ctl.tick && sel_cur && (alarm_ff == TICK_WIDTH'(1));

endmodule

>>> rtl/round_robin_tick_scheduler.sv
// round robin tick scheduler top level: cell row and scan sequencer
//
// One request beat carries one event and produces exactly one response beat.
// A slot write (mode 1), an alarm write (mode 2) or a no-op (mode 3) is applied
// at the accepting edge and answered from S_FIN, which loads the response
// register. A timer tick is applied to all process cells at once at the
// accepting edge (sleep countdown, alarm countdown of the running process,
// running process back to ready); then a single scan token walks the cell row
// one slot per cycle, starting after the running process and skipping the idle
// process 0, until it reaches a ready cell. The token visits between 1 and
// NUM_PROCS-1 slots; if none of them is ready, the idle process 0 runs. The
// response register frees the input side as soon as it is loaded; if the
// previous response has not been taken, the finishing step waits for it.
// No clearing pass is needed after reset: every cell resets directly.
module round_robin_tick_scheduler #(
   parameter int NUM_PROCS  = rrts_pkg::NUM_PROCS_DEFAULT,
   parameter int TICK_WIDTH = rrts_pkg::TICK_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rrts_stream_if.sink   req_bus,
   rrts_stream_if.source rsp_bus
);
   import rrts_pkg::*;

   localparam int IDX_W = $clog2(NUM_PROCS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FIN
   } state_type;

   state_type       state_ff, state_in;
   logic [IDX_W-1:0] running_ff, running_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [COUNT_W-1:0] switches_ff, switches_in;
   logic             fired_ff, fired_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   cell_ctl_type     ctl;
   logic             req_fire;
   logic             out_free;
   logic             any_hit;
   logic             last_step;
   logic             commit;
   logic             switched;
   logic [IDX_W-1:0] commit_idx;
   logic [IDX_W-1:0] start_idx;
   logic [IDX_W-1:0] pos_next;

   logic [NUM_PROCS-1:0] tok;
   logic [NUM_PROCS-1:0] hit;
   logic [NUM_PROCS-1:0] expire;

   // handshake: one event in flight at a time
   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // slot after the running one, wrapping to 1 so the idle process is skipped
   always_comb begin
      if (running_ff == IDX_W'(NUM_PROCS - 1)) begin
         start_idx = IDX_W'(1);
      end else begin
         start_idx = running_ff + 1'b1;
      end
      if (pos_ff == IDX_W'(NUM_PROCS - 1)) begin
         pos_next = IDX_W'(1);
      end else begin
         pos_next = pos_ff + 1'b1;
      end
   end

   assign any_hit   = |hit;
   assign last_step = (step_ff == IDX_W'(NUM_PROCS - 2));
   // no ready slot found: stay with the idle process
   assign commit_idx = any_hit ? pos_ff : '0;
   assign commit     = (state_ff == S_SCAN) && (any_hit || last_step) && out_free;
   assign switched   = (commit_idx != running_ff);

   always_comb begin
      ctl.tick      = req_fire && (req_bus.payload.mode == MODE_TICK);
      ctl.slot_wr   = req_fire && (req_bus.payload.mode == MODE_SLOT)
                      && (int'(req_bus.payload.process_id) < NUM_PROCS);
      ctl.alarm_wr  = req_fire && (req_bus.payload.mode == MODE_ALARM);
      ctl.tok_load  = ctl.tick;
      ctl.tok_shift = (state_ff == S_SCAN) && !any_hit && !last_step;
   end

   // cell row; the token ring runs 1 -> 2 -> ... -> NUM_PROCS-1 -> 1
   for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
      logic tok_from_prev;

      if (i == 0) begin : g_idle
         assign tok_from_prev = 1'b0;
      end else if (i == 1) begin : g_first
         assign tok_from_prev = tok[NUM_PROCS-1];
      end else begin : g_rest
         assign tok_from_prev = tok[i-1];
      end

      rrts_cell #(
         .TICK_WIDTH (TICK_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .sel_cur       (running_ff == IDX_W'(i)),
         .sel_slot      (int'(req_bus.payload.process_id) == i),
         .sel_start     (start_idx == IDX_W'(i)),
         .sel_commit    (commit && (commit_idx == IDX_W'(i))),
         .wr_status     (status_type'(req_bus.payload.new_status)),
         .wr_sleep      (TICK_WIDTH'(req_bus.payload.sleep_ticks)),
         .wr_period     (TICK_WIDTH'(req_bus.payload.alarm_period)),
         .tok_from_prev (tok_from_prev),
         .tok           (tok[i]),
         .hit           (hit[i]),
         .alarm_expire  (expire[i])
      );
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      switches_in  = switches_ff;
      fired_in     = fired_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (ctl.tick) begin
                  pos_in   = start_idx;
                  step_in  = '0;
                  fired_in = |expire;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            if (commit) begin
               running_in = commit_idx;
               if (switched) begin
                  switches_in = switches_ff + 1'b1;
               end
               rsp_valid_in            = 1'b1;
               rsp_in.current_pid      = PID_W'(commit_idx);
               rsp_in.switched         = switched;
               rsp_in.alarm_fired      = fired_ff;
               rsp_in.switch_count     = switched ? switches_ff + 1'b1 : switches_ff;
               state_in                = S_IDLE;
            end else if (ctl.tok_shift) begin
               pos_in  = pos_next;
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.current_pid  = PID_W'(running_ff);
               rsp_in.switched     = 1'b0;
               rsp_in.alarm_fired  = 1'b0;
               rsp_in.switch_count = switches_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         switches_ff  <= '0;
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         switches_ff  <= switches_in;
         fired_ff     <= fired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // exactly one scan token lives in the row while scanning
   a_token_onehot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> $onehot(tok))
      else $error("scan token not one-hot");

   // the position counter follows the token
   a_pos_tracks_token : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> tok[pos_ff])
      else $error("scan position does not match token");

   // a non-idle running process is always found again by the scan
   a_busy_finds_ready : assert property (@(posedge clock) disable iff (reset)
      (commit && running_ff != '0) |-> any_hit)
      else $error("scan ended without a ready slot");

   // a tick finishes with a response beat loaded
   a_commit_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("commit did not load a response");

endmodule

>>> test/tb.sv
// testbench of the round robin tick scheduler: random events against a scoreboard
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrts_pkg::*;

   localparam int NPROC = NUM_PROCS_DEFAULT;
   localparam int PHASE_ITEMS = 350;

   // scheduler shadow state and the queue of responses still owed by the block
   class rrts_scoreboard;
      status_type      slot_state [NPROC];
      bit [31:0]       sleep_cnt [NPROC];
      bit [31:0]       alarm_cnt [NPROC];
      bit [31:0]       alarm_period [NPROC];
      int              run_pid;
      bit [31:0]       switch_total;
      rsp_payload_type rsp_due [$];
      int              fail_count;

      function new();
         foreach (slot_state[i]) begin
            slot_state[i]   = ST_UNUSED;
            sleep_cnt[i]    = '0;
            alarm_cnt[i]    = '0;
            alarm_period[i] = '0;
         end
         run_pid      = 0;
         switch_total = '0;
         fail_count   = 0;
      endfunction

      // round robin over 1..NPROC-1 starting after cur; 0 only as fallback
      function int pick_next(int cur);
         int p;
         if (cur == 0) begin
            for (p = 1; p < NPROC; p++)
               if (slot_state[p] == ST_READY) return p;
            return 0;
         end
         p = cur;
         for (int n = 0; n < NPROC - 1; n++) begin
            p = (p + 1 >= NPROC) ? 1 : p + 1;
            if (slot_state[p] == ST_READY) return p;
         end
         return 0;
      endfunction

      // apply one accepted event and queue the response it must produce
      function void note_event(req_payload_type ev);
         rsp_payload_type r;
         int              cur;
         int              nxt;
         cur           = run_pid;
         r.switched    = 1'b0;
         r.alarm_fired = 1'b0;
         case (mode_type'(ev.mode))
            MODE_TICK: begin
               for (int i = 0; i < NPROC; i++) begin
                  if (slot_state[i] == ST_WAITING && sleep_cnt[i] != 0) begin
                     sleep_cnt[i]--;
                     if (sleep_cnt[i] == 0) slot_state[i] = ST_READY;
                  end
               end
               if (alarm_cnt[cur] != 0) begin
                  alarm_cnt[cur]--;
                  if (alarm_cnt[cur] == 0) begin
                     r.alarm_fired  = 1'b1;
                     alarm_cnt[cur] = alarm_period[cur];
                  end
               end
               slot_state[cur] = ST_READY;
               nxt = pick_next(cur);
               if (nxt != cur) begin
                  r.switched = 1'b1;
                  switch_total++;
               end
               slot_state[nxt] = ST_RUNNING;
               run_pid         = nxt;
            end
            MODE_SLOT: begin
               if (ev.process_id < NPROC) begin
                  slot_state[ev.process_id] = status_type'(ev.new_status);
                  sleep_cnt[ev.process_id]  = ev.sleep_ticks;
               end
            end
            MODE_ALARM: begin
               alarm_period[cur] = ev.alarm_period;
               alarm_cnt[cur]    = ev.alarm_period;
            end
            default: ;
         endcase
         r.current_pid  = run_pid[PID_W-1:0];
         r.switch_count = switch_total;
         rsp_due.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (rsp_due.size() == 0) begin
            $display("%0t: response beat with none expected, actual %h", $time, got);
            fail_count++;
            return;
         end
         want = rsp_due.pop_front();
         check_field("current_pid", want.current_pid, got.current_pid);
         check_field("switched", want.switched, got.switched);
         check_field("alarm_fired", want.alarm_fired, got.alarm_fired);
         check_field("switch_count", want.switch_count, got.switch_count);
      endfunction

      function int pending();
         return rsp_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   rrts_stream_if #(.payload_type(req_payload_type)) req_bus ();
   rrts_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   round_robin_tick_scheduler i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rrts_scoreboard sb = new();

   // idle percentages of sender and receiver for the current phase
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // receiver: ready redrawn every cycle, one assignment per edge
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: responses first so a beat never matches the event accepted on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_response(rsp_bus.payload);
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_event(req_bus.payload);
      end
   end

   // global watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_payload_type make_event(mode_type m, logic [PID_W-1:0] pid,
                                                  status_type st, logic [31:0] sleep_val,
                                                  logic [31:0] period);
      req_payload_type ev;
      ev.mode         = m;
      ev.process_id   = pid;
      ev.new_status   = st;
      ev.sleep_ticks  = sleep_val;
      ev.alarm_period = period;
      return ev;
   endfunction

   // counter values: mostly short so sleeps expire and alarms fire often
   function automatic logic [31:0] tick_value();
      int roll;
      roll = $urandom_range(9);
      case (roll)
         0: return '0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(6, 1);
      endcase
   endfunction

   function automatic req_payload_type random_event();
      req_payload_type ev;
      int              roll;
      ev.process_id   = PID_W'($urandom_range(NPROC - 1));
      ev.sleep_ticks  = tick_value();
      ev.alarm_period = tick_value();
      roll = $urandom_range(99);
      // waiting slots dominate so the sleep countdown keeps feeding the ready set
      if (roll < 40)      ev.new_status = ST_WAITING;
      else if (roll < 70) ev.new_status = ST_READY;
      else if (roll < 85) ev.new_status = ST_UNUSED;
      else                ev.new_status = ST_RUNNING;
      roll = $urandom_range(99);
      if (roll < 45)      ev.mode = MODE_TICK;
      else if (roll < 80) ev.mode = MODE_SLOT;
      else if (roll < 92) ev.mode = MODE_ALARM;
      else                ev.mode = MODE_NOP;
      return ev;
   endfunction

   // sender: optional gap cycles, then hold the beat until it is taken
   task automatic send_event(req_payload_type ev);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= ev;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // hold off the sender until every owed response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle process, wakeup, alarm reload
      send_event(make_event(MODE_NOP, 4'd9, ST_WAITING, $urandom, $urandom));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_SLOT, 4'd15, ST_READY, '0, '0));
      send_event(make_event(MODE_SLOT, 4'd1, ST_WAITING, 32'd2, '0));
      // waiting with zero sleep never wakes
      send_event(make_event(MODE_SLOT, 4'd2, ST_WAITING, '0, '0));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_ALARM, 4'd0, ST_UNUSED, '0, 32'd1));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      // slot 1 cleared while process 15 runs; the next tick keeps 15 running
      send_event(make_event(MODE_SLOT, 4'd1, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_SLOT, 4'd7, ST_WAITING, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_event(make_event(MODE_ALARM, 4'd15, ST_RUNNING, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_ALARM, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_SLOT, 4'd0, ST_READY, 32'd3, '0));
      send_event(make_event(MODE_SLOT, 4'd8, ST_RUNNING, 32'd1, '0));
      send_event(make_event(MODE_SLOT, 4'd3, ST_READY, 32'd5, 32'hFFFF_FFFF));
      send_event(make_event(MODE_SLOT, 4'd14, ST_WAITING, 32'd1, '0));
      send_event(make_event(MODE_TICK, 4'd15, ST_WAITING, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));
      send_event(make_event(MODE_NOP, 4'd6, ST_READY, '0, '0));
      send_event(make_event(MODE_TICK, 4'd0, ST_UNUSED, '0, '0));

      // random phases: free flow, starved sender, stalled receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin req_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) send_event(random_event());
      end

      drain();
      // a longest tick plus receiver stall tail fits well inside this
      repeat (40) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
